// ----- hw/rtl/hri_pkg.sv -----
// ----------------------------------------------------------------------------
// hri_pkg - shared types and constants of the Halton radical inverse block
// Field widths, datapath widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package hri_pkg;

   localparam int INDEX_W    = 32;  // sample index width
   localparam int RADIX_W    = 8;   // base width
   localparam int FRACTION_W = 24;  // result field width
   localparam int FRAC_BITS  = 24;  // quotient bits formed (8..32)
   localparam int ACC_W      = 40;  // reversed digits and b^k, both below 2^40
   localparam int DIV_STEPS  = INDEX_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture a new transaction
      logic div_step;   // one bit of index / radix
      logic acc;        // fold the digit into reversed value and b^k
      logic frac_step;  // one bit of reversed / b^k
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic idx_zero;   // no digits left
      logic bad;        // radix below two
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/hri_datapath.sv -----
// ----------------------------------------------------------------------------
// hri_datapath - digit extraction, accumulation and scaled division
// Restoring divider for index / radix, one multiply-add per digit, then a
// restoring divider forming reversed / b^k one fraction bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hri_datapath (
   input  wire                              clock,
   input  wire  hri_pkg::cmd_type           cmd,
   input  wire  [hri_pkg::INDEX_W-1:0]      req_sample_index,
   input  wire  [hri_pkg::RADIX_W-1:0]      req_radix,
   output hri_pkg::sts_type                 sts,
   output logic [hri_pkg::FRACTION_W-1:0]   rsp_fraction,
   output logic                             rsp_bad_radix
);

   logic [hri_pkg::INDEX_W-1:0]    idx_ff, idx_in;   // dividend, becomes quotient
   logic [hri_pkg::RADIX_W-1:0]    base_ff, base_in;
   logic [hri_pkg::RADIX_W-1:0]    dig_ff, dig_in;   // partial remainder = digit
   logic [hri_pkg::ACC_W-1:0]      rev_ff, rev_in;   // reversed digits / remainder
   logic [hri_pkg::ACC_W-1:0]      den_ff, den_in;   // b^k
   logic [hri_pkg::FRACTION_W-1:0] q_ff, q_in;
   logic                           bad_ff, bad_in;

   logic [hri_pkg::RADIX_W:0]              dig_sh;
   logic                                   dig_ge;
   logic [hri_pkg::ACC_W+hri_pkg::RADIX_W-1:0] rev_prod;
   logic [hri_pkg::ACC_W+hri_pkg::RADIX_W-1:0] den_prod;
   logic [hri_pkg::ACC_W:0]                rem_sh;
   logic                                   rem_ge;

   always_comb begin
      dig_sh   = {dig_ff, idx_ff[hri_pkg::INDEX_W-1]};
      dig_ge   = dig_sh >= {1'b0, base_ff};
      rev_prod = rev_ff * base_ff;
      den_prod = den_ff * base_ff;
      rem_sh   = {rev_ff, 1'b0};
      rem_ge   = rem_sh >= {1'b0, den_ff};
   end

   always_comb begin
      idx_in  = idx_ff;
      base_in = base_ff;
      dig_in  = dig_ff;
      rev_in  = rev_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      bad_in  = bad_ff;
      priority if (cmd.load) begin
         idx_in  = req_sample_index;
         base_in = req_radix;
         dig_in  = '0;
         rev_in  = '0;
         den_in  = hri_pkg::ACC_W'(1);
         q_in    = '0;
         bad_in  = req_radix < hri_pkg::RADIX_W'(2);
      end else if (cmd.div_step) begin
         idx_in = {idx_ff[hri_pkg::INDEX_W-2:0], dig_ge};
         dig_in = dig_ge ? hri_pkg::RADIX_W'(dig_sh - {1'b0, base_ff})
                         : dig_sh[hri_pkg::RADIX_W-1:0];
      end else if (cmd.acc) begin
         rev_in = rev_prod[hri_pkg::ACC_W-1:0] + hri_pkg::ACC_W'(dig_ff);
         den_in = den_prod[hri_pkg::ACC_W-1:0];
         dig_in = '0;
      end else if (cmd.frac_step) begin
         rev_in = rem_ge ? hri_pkg::ACC_W'(rem_sh - {1'b0, den_ff})
                         : rem_sh[hri_pkg::ACC_W-1:0];
         // shifting left drops the high bits: the field keeps the low bits
         q_in   = {q_ff[hri_pkg::FRACTION_W-2:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      base_ff <= base_in;
      dig_ff  <= dig_in;
      rev_ff  <= rev_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      bad_ff  <= bad_in;
   end

   assign sts.idx_zero  = idx_ff == '0;
   assign sts.bad       = bad_ff;
   assign rsp_fraction  = q_ff;
   assign rsp_bad_radix = bad_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hri_control.sv -----
// ----------------------------------------------------------------------------
// hri_control - sequencer of the Halton radical inverse block
// Steps the datapath through digit division, accumulation and final scaled
// division (none on a bad radix), then strobes the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hri_control (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire  hri_pkg::sts_type   sts,
   output hri_pkg::cmd_type         cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_TEST = 6'b000010,
      S_DIV  = 6'b000100,
      S_ACC  = 6'b001000,
      S_FRAC = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   localparam logic [hri_pkg::CNT_W-1:0] DIV_LAST  = hri_pkg::CNT_W'(hri_pkg::DIV_STEPS - 1);
   localparam logic [hri_pkg::CNT_W-1:0] FRAC_LAST = hri_pkg::CNT_W'(hri_pkg::FRAC_BITS - 1);

   state_type                   state_ff, state_in;
   logic [hri_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            priority if (sts.bad) begin
               state_in = S_DONE;
            end else if (sts.idx_zero) begin
               cnt_in   = FRAC_LAST;
               state_in = S_FRAC;
            end else begin
               cnt_in   = DIV_LAST;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_TEST;
         end
         S_FRAC: begin
            cmd.frac_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;

endmodule

`default_nettype wire

// ----- hw/rtl/halton_radical_inverse_top.sv -----
// ----------------------------------------------------------------------------
// halton_radical_inverse_top - Halton radical inverse, 0.24 fixed point
// Mirrors the base-b digits of a 32-bit index about the radix point.
// ----------------------------------------------------------------------------
// One transaction at a time. A transaction is taken at a clock edge with
// start high and busy low; busy then stays high until the result has been
// shown. The result (rsp_fraction, rsp_bad_radix) is on the ports for exactly
// one cycle with rsp_valid high, and the receiver cannot hold it off, so it
// must take it in that cycle. The block works through the k base-b digits of
// the index (k = 0 for index zero, at most 32 for base 2), then the fraction;
// a bad radix (0 or 1) is answered straight from the test state with fraction
// 0. Each digit is pulled off the index by a one-bit-per-cycle restoring
// divider, after a test and before a multiply-add, and then a
// one-bit-per-cycle divider forms reversed / b^k. The result is exact:
// floor(reversed * 2^FRAC_BITS / b^k), truncated, low 24 bits kept.
// ----------------------------------------------------------------------------
`default_nettype none

module halton_radical_inverse_top (
   input  wire                              clock,
   input  wire                              reset,
   // request side
   input  wire                              start,
   output logic                             busy,
   input  wire  [hri_pkg::INDEX_W-1:0]      req_sample_index,
   input  wire  [hri_pkg::RADIX_W-1:0]      req_radix,
   // response side, one-cycle strobe
   output logic                             rsp_valid,
   output logic [hri_pkg::FRACTION_W-1:0]   rsp_fraction,
   output logic                             rsp_bad_radix
);

   hri_pkg::cmd_type cmd;   // sequencer commands
   hri_pkg::sts_type sts;   // datapath status

   hri_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // load only when the transaction is really taken (cmd.load is gated by idle)
   hri_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_sample_index (req_sample_index),
      .req_radix        (req_radix),
      .sts              (sts),
      .rsp_fraction     (rsp_fraction),
      .rsp_bad_radix    (rsp_bad_radix)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/hri_checker.sv -----
// ----------------------------------------------------------------------------
// hri_checker - port-level checks of the Halton radical inverse block
// Watches the request/response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hri_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              start,
   input wire                              busy,
   input wire [hri_pkg::INDEX_W-1:0]       req_sample_index,
   input wire [hri_pkg::RADIX_W-1:0]       req_radix,
   input wire                              rsp_valid,
   input wire [hri_pkg::FRACTION_W-1:0]    rsp_fraction,
   input wire                              rsp_bad_radix
);

   // a taken transaction makes the block busy
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a transaction was taken");

   // result is a single-cycle strobe
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid longer than one cycle");

   // the block frees up right after the result
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy still high after result");

   // a bad radix gives a zero fraction
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_radix) |-> (rsp_fraction == '0))
      else $error("nonzero fraction with bad radix");

   // a bad radix is flagged as soon as the test state after its taking has seen it
   a_bad_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_radix < hri_pkg::RADIX_W'(2)))
         |=> ##1 (rsp_valid && rsp_bad_radix))
      else $error("bad radix not answered at once");

endmodule

bind halton_radical_inverse_top hri_checker u_hri_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for halton_radical_inverse_top
// A queue of sample index / radix pairs feeds a falling-edge driver. A
// rising-edge monitor predicts each transaction's exact 0.24 radical inverse
// on acceptance and checks every response strobe against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int RANDOM_ITEMS   = 520;
   localparam int TAIL_ITEMS     = 60;    // last transactions go back to back
   localparam int SETTLE_CYCLES  = 1200;  // just over the worst-case latency
   localparam int STALL_LIMIT    = 6000;  // cycles with no transaction at all

   typedef logic [hri_pkg::INDEX_W-1:0]    index_type;
   typedef logic [hri_pkg::RADIX_W-1:0]    radix_type;
   typedef logic [hri_pkg::FRACTION_W-1:0] fraction_type;

   // one request, plus a flag that holds it back until the block has drained
   typedef struct {
      index_type index;
      radix_type radix;
      bit        drain_first;
   } sample_req_type;

   // one predicted response, with its request kept for the log
   typedef struct {
      fraction_type fraction;
      logic         bad;
      index_type    index;
      radix_type    radix;
   } inverse_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   index_type    req_sample_index = '0;
   radix_type    req_radix = '0;
   wire          busy;
   wire          rsp_valid;
   fraction_type rsp_fraction;
   wire          rsp_bad_radix;

   sample_req_type pending_reqs[$];   // requests not yet handed to the block
   inverse_type    awaited[$];        // predictions for transactions in flight
   int             error_count = 0;
   bit             handed_over = 1'b0; // request taken at the last rising edge
   int             stall_cycles = 0;

   halton_radical_inverse_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_index (req_sample_index),
      .req_radix        (req_radix),
      .rsp_valid        (rsp_valid),
      .rsp_fraction     (rsp_fraction),
      .rsp_bad_radix    (rsp_bad_radix)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor. Digits are peeled off the index least significant first and
   // pushed onto the reversed value, so the reversed value over b^k is the
   // mirrored fraction. Both stay below 2^40, so 64 bits is ample. The
   // quotient is then formed one bit at a time, truncating.
   // ------------------------------------------------------------------------
   function automatic inverse_type radical_inverse(input index_type idx,
                                                   input radix_type base);
      inverse_type r;
      logic [63:0] reversed;
      logic [63:0] base_pow;
      logic [63:0] rem;
      logic [63:0] quot;
      index_type   n;
      int          i;
      r.fraction = '0;
      r.bad      = 1'b0;
      r.index    = idx;
      r.radix    = base;
      if (base < 2) begin
         r.bad = 1'b1;
         return r;
      end
      reversed = 64'd0;
      base_pow = 64'd1;
      n = idx;
      while (n != 0) begin
         reversed = reversed * base + 64'(n % base);
         base_pow = base_pow * base;
         n        = n / base;
      end
      rem  = reversed;
      quot = 64'd0;
      for (i = 0; i < hri_pkg::FRAC_BITS; i++) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= base_pow) begin
            rem     = rem - base_pow;
            quot[0] = 1'b1;
         end
      end
      r.fraction = quot[hri_pkg::FRACTION_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   task automatic queue_req(input index_type idx, input radix_type base, input bit drain);
      sample_req_type r;
      r.index       = idx;
      r.radix       = base;
      r.drain_first = drain;
      pending_reqs.push_back(r);
   endtask

   // index shapes: tiny, random length, all ones of random length, full
   function automatic index_type pick_sample_index();
      unique case ($urandom_range(0, 4))
         0:       return index_type'($urandom_range(0, 300));
         1:       return index_type'($urandom >> $urandom_range(0, 31));
         2:       return ~index_type'(0) >> $urandom_range(0, 31);
         default: return index_type'($urandom);
      endcase
   endfunction

   // bases: rejected ones now and then, base 2 (longest digit strings),
   // powers of two, small bases and the full range
   function automatic radix_type pick_radix();
      unique case ($urandom_range(0, 9))
         0:       return radix_type'($urandom_range(0, 1));
         1, 2:    return radix_type'(2);
         3:       return radix_type'(1 << $urandom_range(1, 7));
         4, 5:    return radix_type'($urandom_range(3, 16));
         default: return radix_type'($urandom_range(2, 255));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int k;

      // directed: empty digit string, rejected bases, extremes of both fields
      queue_req(32'd0,          8'd2,   1'b0);
      queue_req(32'd0,          8'd255, 1'b0);
      queue_req(32'd0,          8'd0,   1'b0);
      queue_req(32'hFFFF_FFFF,  8'd0,   1'b0);
      queue_req(32'd0,          8'd1,   1'b0);
      queue_req(32'hFFFF_FFFF,  8'd1,   1'b0);
      queue_req(32'd1,          8'd2,   1'b0);
      queue_req(32'hFFFF_FFFF,  8'd2,   1'b0);   // 32 digits, worst latency
      queue_req(32'h8000_0000,  8'd2,   1'b0);
      queue_req(32'd1,          8'd255, 1'b1);   // wait for an empty block first
      queue_req(32'hFFFF_FFFF,  8'd255, 1'b0);
      queue_req(32'd254,        8'd255, 1'b0);   // largest single digit
      queue_req(32'd255,        8'd255, 1'b0);
      queue_req(32'hFFFF_FFFF,  8'd3,   1'b0);
      queue_req(32'd12345,      8'd10,  1'b0);
      queue_req(32'hDEAD_BEEF,  8'd16,  1'b0);
      queue_req(32'd7,          8'd128, 1'b0);
      queue_req(32'h7FFF_FFFF,  8'd254, 1'b0);
      queue_req(32'hAAAA_AAAA,  8'd5,   1'b0);
      queue_req(32'h5555_5555,  8'd7,   1'b0);

      for (k = 0; k < RANDOM_ITEMS; k++)
         queue_req(pick_sample_index(), pick_radix(),
                   (k == 0) || ($urandom_range(0, 32) == 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || start)
         @(posedge clock);
      while (awaited.size() != 0)
         @(posedge clock);
      // anything still arriving now is a stray response
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: falling edge. A request stays on the ports with start high until
   // the monitor has seen it taken. Between items it may idle in bursts;
   // some bursts only count down while busy is low so the gap lands after the
   // block has finished rather than under its busy time. Quiet stretches
   // toggle at random, and the tail of the run never idles. A request marked
   // drain_first waits until every response is back.
   // ------------------------------------------------------------------------
   int  idle_left     = 0;
   bit  idle_on_ready = 1'b0;
   bit  quiet         = 1'b0;

   always @(negedge clock) begin : driver
      logic           hold;
      sample_req_type nxt;
      hold = start && !handed_over;
      if (reset) begin
         hold = 1'b0;
      end else begin
         if (handed_over) begin
            if ($urandom_range(0, 39) == 0)
               quiet = !quiet;
            if (!quiet && pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0) begin
               idle_left     = $urandom_range(1, 18);
               idle_on_ready = $urandom_range(0, 1);
            end
         end
         if (!hold) begin
            if (idle_left > 0) begin
               if (!idle_on_ready || !busy)
                  idle_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && awaited.size() != 0)) begin
               nxt = pending_reqs.pop_front();
               req_sample_index <= nxt.index;
               req_radix        <= nxt.radix;
               hold = 1'b1;
            end
         end
      end
      start <= hold;
   end

   // ------------------------------------------------------------------------
   // Monitor: rising edge. The response strobe is checked before a new
   // request is predicted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      inverse_type want;
      handed_over = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf(
                  "response with no transaction in flight: fraction %h bad_radix %b",
                  rsp_fraction, rsp_bad_radix));
            end else begin
               want = awaited.pop_front();
               if (rsp_fraction !== want.fraction)
                  report_mismatch($sformatf("fraction index %h radix %0d: got %h want %h",
                                            want.index, want.radix, rsp_fraction, want.fraction));
               if (rsp_bad_radix !== want.bad)
                  report_mismatch($sformatf("bad_radix index %h radix %0d: got %b want %b",
                                            want.index, want.radix, rsp_bad_radix, want.bad));
            end
         end
         if (start && !busy) begin
            awaited.push_back(radical_inverse(req_sample_index, req_radix));
            handed_over = 1'b1;
         end
      end
   end

   // watchdog: a hung block never takes or returns a transaction
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

`default_nettype wire
